// File: hw/rtl/bce_pkg.sv
// Battery charge estimator package: fixed-point constants, curve breakpoints
// and register codes shared by the estimator RTL. No dependencies.
`default_nettype none

package bce_pkg;

    // ADC front end: the sum of ADC_SAMPLES readings is clamped to its full scale
    localparam int ADC_SAMPLES = 16;
    localparam int ADC_BITS    = 12;
    localparam logic [31:0] SUM_MAX = 32'(ADC_SAMPLES * ((1 << ADC_BITS) - 1));

    // Register codes (word index on the configuration port)
    localparam logic [1:0] REG_ADC_GAIN    = 2'd0;
    localparam logic [1:0] REG_READ_INTVL  = 2'd1;
    localparam logic [1:0] REG_BLINK_HALF  = 2'd2;

    localparam logic [15:0] ADC_GAIN_RST   = 16'd25781;
    localparam logic [15:0] READ_INTVL_RST = 16'd1000;
    localparam logic [15:0] BLINK_HALF_RST = 16'd500;

    localparam logic [23:0] FILT_RST = 24'd4200000;

    // Divide by 5 as multiply by reciprocal; exact for dividends below 2^27
    localparam int          DIV5_SHIFT = 29;
    localparam logic [26:0] DIV5_MUL   = 27'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);

    // Discharge curve breakpoints in microvolts
    localparam logic [23:0] V_FULL  = 24'd4150000;
    localparam logic [23:0] V_EMPTY = 24'd3300000;
    localparam logic [23:0] V_KNEE1 = 24'd4000000;
    localparam logic [23:0] V_KNEE2 = 24'd3800000;
    localparam logic [23:0] V_KNEE3 = 24'd3650000;

    localparam logic [6:0] PCT_FULL  = 7'd100;
    localparam logic [6:0] PCT_EMPTY = 7'd0;
    localparam logic [6:0] PCT_BASE1 = 7'd80;
    localparam logic [6:0] PCT_BASE2 = 7'd50;
    localparam logic [6:0] PCT_BASE3 = 7'd20;

    // Segment slopes reduce to offset/D (offset*3/D on the middle segment);
    // exact while offset*D stays below 2^CURVE_SHIFT
    localparam int          CURVE_SHIFT = 34;
    localparam logic [21:0] CURVE_M1 = 22'(((64'd1 << CURVE_SHIFT) + 64'd7499) / 64'd7500);
    localparam logic [21:0] CURVE_M2 = 22'(((64'd1 << CURVE_SHIFT) + 64'd19999) / 64'd20000);
    localparam logic [21:0] CURVE_M3 = 22'(((64'd1 << CURVE_SHIFT) + 64'd4999) / 64'd5000);
    localparam logic [21:0] CURVE_M4 = 22'(((64'd1 << CURVE_SHIFT) + 64'd17499) / 64'd17500);

    localparam logic [6:0] SEG4_PCT = 7'd80;
    localparam logic [6:0] SEG3_PCT = 7'd60;
    localparam logic [6:0] SEG2_PCT = 7'd40;
    localparam logic [6:0] SEG1_PCT = 7'd20;

    typedef struct packed {
        logic        icon_visible;
        logic        low_battery;
        logic [2:0]  segments;
        logic [6:0]  percentage;
        logic [23:0] voltage_uv;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/battery_charge_estimator_unit.sv
// Battery charge estimator: five-stage pipeline from tick item to result item.
// Depends on bce_pkg for constants and the result layout.
//
// One tick item is taken per clock cycle unless intake is stopped. Its result
// item is registered through stages 1 to 4 and the output register, which
// holds it until the result side is ready. Stage 1 checks the read timer and
// clamps the ADC sum, stage 2 scales it to microvolts, stage 3 closes the 4:1
// filter loop (a multiply by the reciprocal of 5), stage 4 maps voltage to
// percent on the discharge curve, and the output register derives segments and
// the blink state. Stages move independently, so bubbles collapse; a result
// held by a stalled output stops intake only once all five stages are full.
`default_nettype none

module battery_charge_estimator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // now_ms[31:0], adc_sum[47:32]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // voltage_uv[23:0], percentage[30:24],
                                             // segments[33:31], low_battery[34],
                                             // icon_visible[35], zero fill[39:36]
    output logic [0:0]       m_axis_tuser,   // sampled[0]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [15:0] r_adc_gain;
    logic [15:0] r_read_intvl;
    logic [15:0] r_blink_half;

    // block state
    logic [31:0] r_last_read;
    logic [31:0] r_last_blink;
    logic        r_blink_on;
    logic [23:0] r_filt;

    // pipeline registers
    logic        r_v1, r_v2, r_v3, r_v4, r_ov;
    logic [31:0] r_now1, r_now2, r_now3, r_now4;
    logic        r_took1, r_took2, r_took3, r_took4;
    logic [15:0] r_sum1;
    logic [23:0] r_raw2, r_uv3, r_uv4;
    logic [6:0]  r_pct4;
    bce_pkg::t_result r_out;
    logic        r_out_took;

    logic en1, en2, en3, en4, en5;
    logic [31:0] in_now;
    logic [15:0] in_sum, sum_clamped;
    logic        took;

    // ---------------- configuration port ----------------
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        case (cfg_idx)
            bce_pkg::REG_ADC_GAIN:   prdata = {16'd0, r_adc_gain};
            bce_pkg::REG_READ_INTVL: prdata = {16'd0, r_read_intvl};
            bce_pkg::REG_BLINK_HALF: prdata = {16'd0, r_blink_half};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_gain   <= bce_pkg::ADC_GAIN_RST;
            r_read_intvl <= bce_pkg::READ_INTVL_RST;
            r_blink_half <= bce_pkg::BLINK_HALF_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bce_pkg::REG_ADC_GAIN:   r_adc_gain   <= pwdata[15:0];
                bce_pkg::REG_READ_INTVL: r_read_intvl <= pwdata[15:0];
                bce_pkg::REG_BLINK_HALF: r_blink_half <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage enables ----------------
    assign en5 = !r_ov || m_axis_tready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_ov <= r_v4;
        end
    end

    // ---------------- stage 1: read timer, clamp ----------------
    logic [31:0] n_last_read;

    assign in_now = s_axis_tdata[31:0];
    assign in_sum = s_axis_tdata[47:32];
    assign took   = (in_now - r_last_read) >= {16'd0, r_read_intvl};
    assign sum_clamped = ({16'd0, in_sum} > bce_pkg::SUM_MAX) ?
                         bce_pkg::SUM_MAX[15:0] : in_sum;
    assign n_last_read = (s_axis_tvalid && en1 && took) ? in_now : r_last_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_read <= 32'd0;
        end else begin
            r_last_read <= n_last_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_now1  <= in_now;
            r_sum1  <= sum_clamped;
            r_took1 <= took;
        end
    end

    // ---------------- stage 2: scale to microvolts ----------------
    logic [31:0] scale_prod;

    // 16x16 Q8 product shifted down always fits 24 bits
    assign scale_prod = 32'(r_sum1) * 32'(r_adc_gain);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_now2  <= r_now1;
            r_took2 <= r_took1;
            r_raw2  <= scale_prod[31:8];
        end
    end

    // ---------------- stage 3: exponential filter ----------------
    logic [26:0] mix_sum;
    logic [53:0] mix_prod;
    logic [23:0] n_filt;

    assign mix_sum  = 27'({r_filt, 2'b00}) + 27'(r_raw2);
    assign mix_prod = 54'(mix_sum) * 54'(bce_pkg::DIV5_MUL);
    assign n_filt   = mix_prod[bce_pkg::DIV5_SHIFT +: 24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= bce_pkg::FILT_RST;
        end else if (en3 && r_v2 && r_took2) begin
            r_filt <= n_filt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_now3  <= r_now2;
            r_took3 <= r_took2;
            r_uv3   <= r_took2 ? n_filt : r_filt;
        end
    end

    // ---------------- stage 4: discharge curve ----------------
    logic [18:0] c_d;
    logic [19:0] c_x;
    logic [21:0] c_m;
    logic [6:0]  c_base;
    logic [41:0] c_prod;
    logic [6:0]  n_pct;

    always_comb begin
        c_d    = 19'd0;
        c_x    = 20'd0;
        c_m    = 22'd0;
        c_base = bce_pkg::PCT_EMPTY;
        if (r_uv3 >= bce_pkg::V_FULL) begin
            c_base = bce_pkg::PCT_FULL;
        end else if (r_uv3 <= bce_pkg::V_EMPTY) begin
            c_base = bce_pkg::PCT_EMPTY;
        end else if (r_uv3 > bce_pkg::V_KNEE1) begin
            c_base = bce_pkg::PCT_BASE1;
            c_x    = 20'(r_uv3 - bce_pkg::V_KNEE1);
            c_m    = bce_pkg::CURVE_M1;
        end else if (r_uv3 > bce_pkg::V_KNEE2) begin
            // slope 30/200000 is 3/20000: triple the offset
            c_base = bce_pkg::PCT_BASE2;
            c_d    = 19'(r_uv3 - bce_pkg::V_KNEE2);
            c_x    = {1'b0, c_d} + {c_d, 1'b0};
            c_m    = bce_pkg::CURVE_M2;
        end else if (r_uv3 > bce_pkg::V_KNEE3) begin
            c_base = bce_pkg::PCT_BASE3;
            c_x    = 20'(r_uv3 - bce_pkg::V_KNEE3);
            c_m    = bce_pkg::CURVE_M3;
        end else begin
            c_base = bce_pkg::PCT_EMPTY;
            c_x    = 20'(r_uv3 - bce_pkg::V_EMPTY);
            c_m    = bce_pkg::CURVE_M4;
        end
    end

    assign c_prod = 42'(c_x) * 42'(c_m);
    assign n_pct  = c_base + 7'(c_prod[bce_pkg::CURVE_SHIFT +: 5]);

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_now4  <= r_now3;
            r_took4 <= r_took3;
            r_uv4   <= r_uv3;
            r_pct4  <= n_pct;
        end
    end

    // ---------------- stage 5: segments, blink, output register ----------------
    logic [2:0]  n_seg;
    logic        seg_zero;
    logic        blink_due;
    logic        n_blink_on;
    logic [31:0] n_last_blink;

    always_comb begin
        if (r_pct4 >= bce_pkg::SEG4_PCT)      n_seg = 3'd4;
        else if (r_pct4 >= bce_pkg::SEG3_PCT) n_seg = 3'd3;
        else if (r_pct4 >= bce_pkg::SEG2_PCT) n_seg = 3'd2;
        else if (r_pct4 >= bce_pkg::SEG1_PCT) n_seg = 3'd1;
        else                                  n_seg = 3'd0;
    end

    assign seg_zero  = (n_seg == 3'd0);
    assign blink_due = (r_now4 - r_last_blink) >= {16'd0, r_blink_half};

    always_comb begin
        n_blink_on   = r_blink_on;
        n_last_blink = r_last_blink;
        if (en5 && r_v4) begin
            if (seg_zero) begin
                // toggle each half period while empty
                if (blink_due) begin
                    n_last_blink = r_now4;
                    n_blink_on   = !r_blink_on;
                end
            end else begin
                n_blink_on = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_blink <= 32'd0;
            r_blink_on   <= 1'b1;
        end else begin
            r_last_blink <= n_last_blink;
            r_blink_on   <= n_blink_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_out.voltage_uv   <= r_uv4;
            r_out.percentage   <= r_pct4;
            r_out.segments     <= n_seg;
            r_out.low_battery  <= seg_zero;
            r_out.icon_visible <= n_blink_on;
            r_out_took         <= r_took4;
        end
    end

    assign m_axis_tvalid   = r_ov;
    assign m_axis_tdata    = {4'd0, r_out};
    assign m_axis_tuser[0] = r_out_took;

endmodule

`default_nettype wire
